/* hw/rtl/sfla_pkg.sv */
// Shared types, constants and helpers for the slot free-list allocator.
`timescale 1ns / 1ps
`default_nettype none

package sfla_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int CNT32_W    = 32;

    typedef enum logic [1:0] {
        ALLOC_IDLE,
        ALLOC_FETCH,
        ALLOC_UPDATE
    } alloc_state_t;

    typedef enum logic [2:0] {
        STATUS_GRANTED  = 3'd0,
        STATUS_EMPTY    = 3'd1,
        STATUS_RELEASED = 3'd2,
        STATUS_RANGE    = 3'd3,
        STATUS_INACTIVE = 3'd4
    } status_t;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic               active;
        logic [CNT32_W-1:0] uses;
    } slot_entry_t;

    function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] v);
        sat_inc = (v == {CNT32_W{1'b1}}) ? v : v + CNT32_W'(1);
    endfunction

    function automatic logic [COUNT_W-1:0] clamp_size(input logic [COUNT_W-1:0] v);
        if (v == '0) begin
            clamp_size = COUNT_W'(1);
        end else if (v > COUNT_W'(SLOT_COUNT)) begin
            clamp_size = COUNT_W'(SLOT_COUNT);
        end else begin
            clamp_size = v;
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/slot_free_list_allocator.sv */
// Slot allocator: LIFO free-index stack and per-slot state held in on-chip memories.
//
// Use:
//   Input beats carry one request: s_tuser[0] is the opcode (acquire or release),
//   s_tdata[9:0] the slot to release. Each request yields exactly one result beat:
//   m_tuser[2:0] is the status, m_tdata packs the slot, its use count, the free and
//   active slot counts and the three saturating event counters.
//   cfg_wr_en/cfg_wr_data write the pool size (0 taken as 1, above 1024 as 1024);
//   a write refills the free stack and clears all slot state, event counters kept.
// Request flow:
//   A release or empty-pool acquire goes from IDLE to UPDATE; a grant passes FETCH,
//   since the popped index must come out of the stack memory before the slot memory
//   can be read at it. One request is in flight at a time; s_tready is high again
//   once the result is registered.
// Reset and refill:
//   After reset and after every pool size write, a sweep rewrites all 1024 entries of
//   both memories (stack entry i = i, slot entry cleared); s_tready stays low then.
// Stall:
//   The result waits in the output register while m_tready is low. A new request
//   may still be accepted and read its memories, but it holds before its write-back
//   until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module slot_free_list_allocator
    import sfla_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         cfg_wr_en,
    input  wire logic [10:0]  cfg_wr_data,   // pool_size

    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,       // [9:0] slot_index, [15:10] zero
    input  wire logic [0:0]   s_tuser,       // [0] opcode

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [9:0] slot, [41:10] slot_uses, [52:42] free_slots, [63:53] active_slots,
    // [95:64] grants_total, [127:96] failures_total, [159:128] releases_total
    output logic [159:0]      m_tdata,
    output logic [2:0]        m_tuser        // [2:0] status
);

    // Control state
    alloc_state_t        state_reg, state_next;
    logic                clearing_reg, clearing_next;
    logic [SLOT_W-1:0]   sweep_idx_reg, sweep_idx_next;
    logic [COUNT_W-1:0]  pool_size_reg, pool_size_next;
    logic [COUNT_W-1:0]  stack_top_reg, stack_top_next;
    logic [COUNT_W-1:0]  active_total_reg, active_total_next;
    logic [CNT32_W-1:0]  grant_cnt_reg, grant_cnt_next;
    logic [CNT32_W-1:0]  fail_cnt_reg, fail_cnt_next;
    logic [CNT32_W-1:0]  release_cnt_reg, release_cnt_next;
    logic                out_valid_reg, out_valid_next;

    // Request and result payload
    opcode_t             op_reg, op_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    status_t             out_status_reg, out_status_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [CNT32_W-1:0]  out_uses_reg, out_uses_next;

    // Memories
    logic [SLOT_W-1:0]   stack_mem [SLOT_COUNT];
    slot_entry_t         slot_mem  [SLOT_COUNT];
    logic [SLOT_W-1:0]   stack_rd_reg;
    slot_entry_t         slot_rd_reg;

    logic                stack_we, stack_re;
    logic [SLOT_W-1:0]   stack_wr_addr, stack_wr_data, stack_rd_addr;
    logic                slot_we, slot_re;
    logic [SLOT_W-1:0]   slot_wr_addr, slot_rd_addr;
    slot_entry_t         slot_wr_data;

    logic                accept;
    logic                out_free;
    logic [COUNT_W-1:0]  top_dec;
    logic [CNT32_W-1:0]  uses_inc;
    logic [COUNT_W-1:0]  cfg_size;

    assign s_tready = (state_reg == ALLOC_IDLE) && !clearing_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign top_dec  = stack_top_reg - COUNT_W'(1);
    assign uses_inc = sat_inc(slot_rd_reg.uses);
    assign cfg_size = clamp_size(cfg_wr_data);

    // Counters go straight to the port: event counters move only with the output
    // register load and so match its result; pool size writes reset free/active counts.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {release_cnt_reg, fail_cnt_reg, grant_cnt_reg,
                       active_total_reg, stack_top_reg, out_uses_reg, out_slot_reg};

    always_comb begin
        state_next        = state_reg;
        clearing_next     = clearing_reg;
        sweep_idx_next    = sweep_idx_reg;
        pool_size_next    = pool_size_reg;
        stack_top_next    = stack_top_reg;
        active_total_next = active_total_reg;
        grant_cnt_next    = grant_cnt_reg;
        fail_cnt_next     = fail_cnt_reg;
        release_cnt_next  = release_cnt_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        op_next           = op_reg;
        idx_next          = idx_reg;
        out_status_next   = out_status_reg;
        out_slot_next     = out_slot_reg;
        out_uses_next     = out_uses_reg;

        stack_re      = 1'b0;
        stack_rd_addr = top_dec[SLOT_W-1:0];
        stack_we      = 1'b0;
        stack_wr_addr = stack_top_reg[SLOT_W-1:0];
        stack_wr_data = idx_reg;
        slot_re       = 1'b0;
        slot_rd_addr  = stack_rd_reg;
        slot_we       = 1'b0;
        slot_wr_addr  = stack_rd_reg;
        slot_wr_data  = '{active: 1'b1, uses: uses_inc};

        unique case (state_reg)
            ALLOC_IDLE: begin
                if (accept) begin
                    op_next  = opcode_t'(s_tuser[0]);
                    idx_next = s_tdata[SLOT_W-1:0];
                    if (opcode_t'(s_tuser[0]) == OP_ACQUIRE) begin
                        // peek the top of stack now; an empty stack skips the fetch
                        stack_re   = 1'b1;
                        state_next = (stack_top_reg != '0) ? ALLOC_FETCH : ALLOC_UPDATE;
                    end else begin
                        slot_re      = 1'b1;
                        slot_rd_addr = s_tdata[SLOT_W-1:0];
                        state_next   = ALLOC_UPDATE;
                    end
                end
            end
            ALLOC_FETCH: begin
                slot_re      = 1'b1;
                slot_rd_addr = stack_rd_reg;
                state_next   = ALLOC_UPDATE;
            end
            ALLOC_UPDATE: begin
                // hold the write-back until the output register can take the result
                if (out_free) begin
                    state_next     = ALLOC_IDLE;
                    out_valid_next = 1'b1;
                    out_slot_next  = '0;
                    out_uses_next  = '0;
                    if (op_reg == OP_ACQUIRE) begin
                        if (stack_top_reg == '0) begin
                            fail_cnt_next   = sat_inc(fail_cnt_reg);
                            out_status_next = STATUS_EMPTY;
                        end else begin
                            stack_top_next = top_dec;
                            slot_we        = 1'b1;
                            if (!slot_rd_reg.active) begin
                                active_total_next = active_total_reg + COUNT_W'(1);
                            end
                            grant_cnt_next  = sat_inc(grant_cnt_reg);
                            out_status_next = STATUS_GRANTED;
                            out_slot_next   = stack_rd_reg;
                            out_uses_next   = uses_inc;
                        end
                    end else begin
                        if ({1'b0, idx_reg} >= pool_size_reg) begin
                            out_status_next = STATUS_RANGE;
                        end else if (!slot_rd_reg.active) begin
                            out_status_next = STATUS_INACTIVE;
                        end else begin
                            slot_we      = 1'b1;
                            slot_wr_addr = idx_reg;
                            slot_wr_data = '{active: 1'b0, uses: slot_rd_reg.uses};
                            if (active_total_reg != '0) begin
                                active_total_next = active_total_reg - COUNT_W'(1);
                            end
                            // push back the released index
                            if (stack_top_reg < COUNT_W'(SLOT_COUNT)) begin
                                stack_we       = 1'b1;
                                stack_top_next = stack_top_reg + COUNT_W'(1);
                            end
                            release_cnt_next = sat_inc(release_cnt_reg);
                            out_status_next  = STATUS_RELEASED;
                            out_slot_next    = idx_reg;
                            out_uses_next    = slot_rd_reg.uses;
                        end
                    end
                end
            end
            default: begin
                state_next = ALLOC_IDLE;
            end
        endcase

        // Refill sweep: one entry of each memory per cycle, no requests taken meanwhile
        if (clearing_reg) begin
            stack_we       = 1'b1;
            stack_wr_addr  = sweep_idx_reg;
            stack_wr_data  = sweep_idx_reg;
            slot_we        = 1'b1;
            slot_wr_addr   = sweep_idx_reg;
            slot_wr_data   = '{active: 1'b0, uses: '0};
            sweep_idx_next = sweep_idx_reg + SLOT_W'(1);
            if (sweep_idx_reg == SLOT_W'(SLOT_COUNT - 1)) begin
                clearing_next = 1'b0;
            end
        end

        // Pool size write: restart the sweep and reset the stack pointer
        if (cfg_wr_en) begin
            pool_size_next    = cfg_size;
            stack_top_next    = cfg_size;
            active_total_next = '0;
            clearing_next     = 1'b1;
            sweep_idx_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ALLOC_IDLE;
            clearing_reg     <= 1'b1;
            sweep_idx_reg    <= '0;
            pool_size_reg    <= COUNT_W'(SLOT_COUNT);
            stack_top_reg    <= COUNT_W'(SLOT_COUNT);
            active_total_reg <= '0;
            grant_cnt_reg    <= '0;
            fail_cnt_reg     <= '0;
            release_cnt_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clearing_reg     <= clearing_next;
            sweep_idx_reg    <= sweep_idx_next;
            pool_size_reg    <= pool_size_next;
            stack_top_reg    <= stack_top_next;
            active_total_reg <= active_total_next;
            grant_cnt_reg    <= grant_cnt_next;
            fail_cnt_reg     <= fail_cnt_next;
            release_cnt_reg  <= release_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_uses_reg   <= out_uses_next;
    end

    // Free-index stack memory
    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_wr_addr] <= stack_wr_data;
        end
        if (stack_re) begin
            stack_rd_reg <= stack_mem[stack_rd_addr];
        end
    end

    // Per-slot active flag and use count memory
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        if (slot_re) begin
            slot_rd_reg <= slot_mem[slot_rd_addr];
        end
    end

endmodule

`default_nettype wire
